FILE: rtl/bal_pkg.sv
// Shared types and codes for the bounded array list.
package bal_pkg;

    localparam int FUNC_W = 3;
    localparam int IDX_W  = 10;
    localparam int VAL_W  = 32;
    localparam int ST_W   = 2;
    localparam int CNT_W  = 11;

    localparam logic [FUNC_W-1:0] FN_READ   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_SEARCH = 3'd1;
    localparam logic [FUNC_W-1:0] FN_APPEND = 3'd2;
    localparam logic [FUNC_W-1:0] FN_INSERT = 3'd3;
    localparam logic [FUNC_W-1:0] FN_DELETE = 3'd4;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
    localparam logic [ST_W-1:0] ST_MISS  = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [IDX_W-1:0]  index;
        logic [VAL_W-1:0]  value;
    } t_cmd;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [VAL_W-1:0] read_data;
        logic [IDX_W-1:0] found_position;
        logic [CNT_W-1:0] entry_count;
    } t_rsp;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_READ,
        OP_SEARCH,
        OP_APPEND,
        OP_INSERT,
        OP_DELETE
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] index;
        logic [VAL_W-1:0] value;
    } t_job;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SEARCH,
        S_SHIFT
    } t_state;

endpackage

FILE: rtl/bal_front.sv
// Command decode and two-entry job queue in front of the list engine.
module bal_front import bal_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_cmd i_cmd,
    output logic o_busy,
    output logic o_job_valid,
    output t_job o_job,
    input  logic i_job_pop
);

    t_job       r_slot [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_fill;
    t_job       w_job;
    logic       w_push;
    logic       w_pop;

    always_comb begin
        w_job.index = i_cmd.index;
        w_job.value = i_cmd.value;
        unique case (i_cmd.func)
            FN_READ:   w_job.op = OP_READ;
            FN_SEARCH: w_job.op = OP_SEARCH;
            FN_APPEND: w_job.op = OP_APPEND;
            FN_INSERT: w_job.op = OP_INSERT;
            FN_DELETE: w_job.op = OP_DELETE;
            default:   w_job.op = OP_NOP;
        endcase
    end

    assign o_busy      = (r_fill == 2'd2);
    assign w_push      = i_start && !o_busy;
    assign o_job_valid = (r_fill != 2'd0);
    assign w_pop       = i_job_pop && o_job_valid;
    assign o_job       = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr] <= w_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= 1'b0;
            r_rd   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= !r_wr;
            end
            if (w_pop) begin
                r_rd <= !r_rd;
            end
            case ({w_push, w_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

FILE: rtl/bal_back.sv
// List engine: entry memory, count and the read, search and shift sequencer.
module bal_back import bal_pkg::*; #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_job_valid,
    input  t_job i_job,
    output logic o_job_pop,
    output logic o_valid,
    output t_rsp o_rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > CNT_W) ? CW : CNT_W;
    localparam int RW = (DATA_WIDTH > VAL_W) ? DATA_WIDTH : VAL_W;

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    t_op                   r_op, n_op;
    logic [IDX_W-1:0]      r_index, n_index;
    logic [DATA_WIDTH-1:0] r_val, n_val;
    logic [CW-1:0]         r_k, n_k;
    logic [CW-1:0]         r_end, n_end;
    logic [AW-1:0]         r_dst, n_dst;
    logic [AW-1:0]         r_pk, n_pk;
    logic                  r_pend, n_pend;
    logic                  r_more, n_more;
    logic                  r_up, n_up;
    logic                  r_valid, n_valid;
    t_rsp                  r_rsp, n_rsp;

    logic                  w_we, w_re;
    logic [AW-1:0]         w_waddr, w_raddr;
    logic [DATA_WIDTH-1:0] w_wdata;

    logic [XW-1:0]         w_idx_x, w_cnt_x, w_pk_x, w_k_x, w_nxt_x;
    logic [AW-1:0]         w_addr;
    logic                  w_in_range, w_full;
    logic [RW-1:0]         w_rd_x, w_val_x;
    logic [CW-1:0]         w_addr_c;

    assign w_idx_x    = XW'(r_index);
    assign w_cnt_x    = XW'(r_count);
    assign w_pk_x     = XW'(r_pk);
    assign w_k_x      = XW'(r_k);
    assign w_addr     = w_idx_x[AW-1:0];
    assign w_addr_c   = w_idx_x[CW-1:0];
    assign w_nxt_x    = w_idx_x + XW'(1);
    assign w_in_range = (w_idx_x < w_cnt_x);
    assign w_full     = (r_count == CW'(DEPTH));
    assign w_rd_x     = RW'(r_rdata);
    assign w_val_x    = RW'(i_job.value);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
            r_more  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
            r_pend  <= n_pend;
            r_more  <= n_more;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_index <= n_index;
        r_val   <= n_val;
        r_k     <= n_k;
        r_end   <= n_end;
        r_dst   <= n_dst;
        r_pk    <= n_pk;
        r_up    <= n_up;
        r_rsp   <= n_rsp;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_op      = r_op;
        n_index   = r_index;
        n_val     = r_val;
        n_k       = r_k;
        n_end     = r_end;
        n_dst     = r_dst;
        n_pk      = r_pk;
        n_pend    = r_pend;
        n_more    = r_more;
        n_up      = r_up;
        n_valid   = 1'b0;
        n_rsp     = r_rsp;
        o_job_pop = 1'b0;
        w_we      = 1'b0;
        w_waddr   = w_addr;
        w_wdata   = r_val;
        w_re      = 1'b0;
        w_raddr   = w_addr;

        unique case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_op      = i_job.op;
                    n_index   = i_job.index;
                    n_val     = w_val_x[DATA_WIDTH-1:0];
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                n_rsp.status = ST_OK;
                n_rsp.read_data = '0;
                n_rsp.found_position = '0;
                unique case (r_op)
                    OP_READ: begin
                        if (!w_in_range) begin
                            n_rsp.status = ST_RANGE;
                            n_valid = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            w_re    = 1'b1;
                            n_state = S_READ;
                        end
                    end
                    OP_SEARCH: begin
                        n_k     = '0;
                        n_pend  = 1'b0;
                        n_state = S_SEARCH;
                    end
                    OP_APPEND: begin
                        if (w_full) begin
                            n_rsp.status = ST_FULL;
                        end else begin
                            w_we    = 1'b1;
                            w_waddr = r_count[AW-1:0];
                            n_count = r_count + CW'(1);
                        end
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end
                    OP_INSERT: begin
                        if (w_full) begin
                            n_rsp.status = ST_FULL;
                            n_valid = 1'b1;
                            n_state = S_IDLE;
                        end else if (!w_in_range) begin
                            n_rsp.status = ST_RANGE;
                            n_valid = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            n_up    = 1'b1;
                            n_k     = r_count - CW'(1);
                            n_end   = w_addr_c;
                            n_more  = 1'b1;
                            n_pend  = 1'b0;
                            n_state = S_SHIFT;
                        end
                    end
                    OP_DELETE: begin
                        if (!w_in_range) begin
                            n_rsp.status = ST_RANGE;
                            n_valid = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            n_up    = 1'b0;
                            n_k     = w_nxt_x[CW-1:0];
                            n_end   = r_count - CW'(1);
                            n_more  = (w_nxt_x < w_cnt_x);
                            n_pend  = 1'b0;
                            n_state = S_SHIFT;
                        end
                    end
                    default: begin
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_READ: begin
                n_rsp.read_data = w_rd_x[VAL_W-1:0];
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            S_SEARCH: begin
                if (r_pend && (r_rdata == r_val)) begin
                    n_rsp.found_position = w_pk_x[IDX_W-1:0];
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else if (w_k_x >= w_cnt_x) begin
                    n_rsp.status = ST_MISS;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = r_k[AW-1:0];
                    n_pk    = r_k[AW-1:0];
                    n_k     = r_k + CW'(1);
                    n_pend  = 1'b1;
                end
            end
            S_SHIFT: begin
                if (r_pend) begin
                    w_we    = 1'b1;
                    w_waddr = r_dst;
                    w_wdata = r_rdata;
                end
                if (r_more) begin
                    w_re    = 1'b1;
                    w_raddr = r_k[AW-1:0];
                    n_pend  = 1'b1;
                    n_more  = (r_k != r_end);
                    if (r_up) begin
                        n_dst = AW'(r_k + CW'(1));
                        n_k   = r_k - CW'(1);
                    end else begin
                        n_dst = AW'(r_k - CW'(1));
                        n_k   = r_k + CW'(1);
                    end
                end else begin
                    n_pend = 1'b0;
                end
                if (!r_pend && !r_more) begin
                    if (r_up) begin
                        w_we    = 1'b1;
                        w_waddr = w_addr;
                        w_wdata = r_val;
                        n_count = r_count + CW'(1);
                    end else begin
                        n_count = r_count - CW'(1);
                    end
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_rsp.entry_count = CNT_W'(n_count);
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

FILE: rtl/bounded_array_list.sv
// Bounded array list top level: command queue in front of the list engine.
// Takes one command word while busy is low and start is high; up to two
// commands wait in a queue while the engine works. Each command gives one
// response word, shown on o_rsp for exactly one cycle with o_valid high; the
// receiver cannot stall it. After the engine takes a command from the queue,
// append, range and full errors and unknown functions answer from the execute
// state; a read answers after one memory read; search ends at the first match
// or at the count; insert and delete shift the entries between index and end.
// Search and shifts walk the entries one a cycle through the memory's single
// read port, so the time of such a command grows with the entries it walks.
module bounded_array_list import bal_pkg::*; #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_cmd i_cmd,
    output logic busy,
    output logic o_valid,
    output t_rsp o_rsp
);

    logic w_job_valid;
    t_job w_job;
    logic w_job_pop;

    bal_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_cmd       (i_cmd),
        .o_busy      (busy),
        .o_job_valid (w_job_valid),
        .o_job       (w_job),
        .i_job_pop   (w_job_pop)
    );

    bal_back #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_job),
        .o_job_pop   (w_job_pop),
        .o_valid     (o_valid),
        .o_rsp       (o_rsp)
    );

endmodule
